// ===== hw/rtl/pfvd_pkg.sv =====
// Shared types and codes for the polygon fan vertex dedup block.
// Used by pfvd_resolve and polygon_fan_vertex_dedup.
package pfvd_pkg;

	// fixed field widths of the stream payload
	localparam int RAW_W     = 22;
	localparam int COUNT_W   = 21;
	localparam int OUT_IDX_W = 20;
	localparam int RI_OUT_W  = 12;
	localparam int KIND_W    = 3;
	localparam int ERR_W     = 3;
	localparam int CNUM_W    = 8;
	localparam int MASK_W    = 5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_VERTEX = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PTRI   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RTRI   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

	// error codes
	localparam logic [ERR_W-1:0] ERR_ZERO   = 3'd0;
	localparam logic [ERR_W-1:0] ERR_POS    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_TEX    = 3'd2;
	localparam logic [ERR_W-1:0] ERR_NORMAL = 3'd3;
	localparam logic [ERR_W-1:0] ERR_SHORT  = 3'd4;
	localparam logic [ERR_W-1:0] ERR_FULL   = 3'd5;

	// pending-result mask bits, in emit order
	localparam int M_VERT  = 0;
	localparam int M_EDGEP = 1;
	localparam int M_EDGEF = 2;
	localparam int M_PTRI  = 3;
	localparam int M_RTRI  = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RES_P,
		ST_RES_T,
		ST_RES_N,
		ST_SEARCH,
		ST_CMP,
		ST_EMIT,
		ST_ERR
	} state_t;

	// resolver status
	typedef struct packed {
		logic zero;
		logic bad;
	} res_status_t;

endpackage

// ===== hw/rtl/polygon_fan_vertex_dedup.sv =====
// Top level of the polygon fan vertex dedup block: sequencer, state and output register.
// Depends on pfvd_pkg, pfvd_resolve and pfvd_table.
//
// One request is one polygon corner. The block takes a corner, resolves its three
// indices one after another through a single shared resolver, then scans the dedup
// table linearly through its one read port, a search and a compare state per stored
// key, inserts the key when it is new, and puts out one result per cycle through an
// output register while the receiver does not hold the output; then it updates the
// face state. The input is not ready until the corner is done. The table needs no
// clearing.
module polygon_fan_vertex_dedup #(
	parameter int TABLE_DEPTH = 4096,
	parameter int INDEX_BITS  = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// position_index[21:0], tex_index[43:22], normal_index[65:44], has_tex[66],
	// normal_flag[67], position_count[88:68], tex_count[109:89], normal_count[130:110]
	input  logic [135:0] s_axis_tdata,
	input  logic         s_axis_tlast,   // face_end
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vertex_idx[11:0], index_a[31:12], index_b[51:32], index_c[71:52],
	// vertex_has_tex[72], vertex_has_normal[73], error_code[76:74]
	output logic [79:0]  m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast    // last
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = 3 * INDEX_BITS + 2;

	localparam logic [pfvd_pkg::MASK_W-1:0] MASK_W_VERT = 5'b00001;

	pfvd_pkg::state_t state_q, state_d;

	// latched corner
	logic [pfvd_pkg::RAW_W-1:0]   pos_raw_q, tex_raw_q, nrm_raw_q;
	logic [pfvd_pkg::COUNT_W-1:0] pos_cnt_q, tex_cnt_q, nrm_cnt_q;
	logic                         ht_q, hn_q, end_q;

	// resolved indices and lookup
	logic [INDEX_BITS-1:0] p_q, t_q, n_q;
	logic [CW-1:0]         idx_q, count_q;
	logic [AW-1:0]         ri_q;
	logic                  new_q;
	logic [pfvd_pkg::MASK_W-1:0] mask_q;
	logic [pfvd_pkg::ERR_W-1:0]  err_q, err_d;

	// face state
	logic [INDEX_BITS-1:0] first_p_q, prev_p_q;
	logic [AW-1:0]         first_ri_q, prev_ri_q;
	logic [pfvd_pkg::CNUM_W-1:0] cnum_q;
	logic                  fail_q;

	// shared resolver
	logic [pfvd_pkg::RAW_W-1:0]   res_raw;
	logic [pfvd_pkg::COUNT_W-1:0] res_cnt;
	pfvd_pkg::res_status_t        res_st;
	logic [INDEX_BITS-1:0]        res_idx;

	// table
	logic             tbl_we;
	logic [KEY_W-1:0] key, tbl_rdata;
	logic             match, table_full, scan_done;

	logic acc, slot_free, out_load, commit;
	logic [pfvd_pkg::MASK_W-1:0] mask_init, mask_rest;
	logic [INDEX_BITS-1:0] lo_p, hi_p, lo_f, hi_f;

	// next result
	logic [79:0]               out_data_d;
	logic [pfvd_pkg::KIND_W-1:0] out_kind_d;
	logic                      out_last_d;

	assign acc        = s_axis_tvalid && s_axis_tready;
	assign slot_free  = !m_axis_tvalid || m_axis_tready;
	assign key        = {hn_q, ht_q, n_q, t_q, p_q};
	assign match      = (tbl_rdata == key);
	assign scan_done  = (idx_q == count_q);
	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign mask_rest  = mask_q & (mask_q - 5'd1);
	assign commit     = (state_q == pfvd_pkg::ST_EMIT) && (mask_q == '0);

	// resolver operand select
	always_comb begin
		case (state_q)
			pfvd_pkg::ST_RES_T: begin
				res_raw = tex_raw_q;
				res_cnt = tex_cnt_q;
			end
			pfvd_pkg::ST_RES_N: begin
				res_raw = nrm_raw_q;
				res_cnt = nrm_cnt_q;
			end
			default: begin
				res_raw = pos_raw_q;
				res_cnt = pos_cnt_q;
			end
		endcase
	end

	pfvd_resolve #(
		.INDEX_BITS(INDEX_BITS)
	) u_resolve (
		.raw   (res_raw),
		.count (res_cnt),
		.status(res_st),
		.idx   (res_idx)
	);

	pfvd_table #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (KEY_W),
		.ADDR_W(AW)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(count_q[AW-1:0]),
		.wdata(key),
		.raddr(idx_q[AW-1:0]),
		.rdata(tbl_rdata)
	);

	// results due for this corner
	always_comb begin
		mask_init                   = '0;
		mask_init[pfvd_pkg::M_VERT]  = 1'b0;
		mask_init[pfvd_pkg::M_EDGEP] = (cnum_q >= 8'd1) && (prev_p_q != p_q);
		mask_init[pfvd_pkg::M_EDGEF] = end_q && (cnum_q >= 8'd2) && (first_p_q != p_q);
		mask_init[pfvd_pkg::M_PTRI]  = (cnum_q >= 8'd2);
		mask_init[pfvd_pkg::M_RTRI]  = (cnum_q >= 8'd2);
	end

	// sequencer: next state and control
	always_comb begin
		state_d       = state_q;
		err_d         = err_q;
		tbl_we        = 1'b0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			pfvd_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (fail_q) begin
						state_d = pfvd_pkg::ST_IDLE;
					end else if (s_axis_tlast && (cnum_q < 8'd2)) begin
						err_d   = pfvd_pkg::ERR_SHORT;
						state_d = pfvd_pkg::ST_ERR;
					end else begin
						state_d = pfvd_pkg::ST_RES_P;
					end
				end
			end
			pfvd_pkg::ST_RES_P: begin
				if (res_st.zero || res_st.bad) begin
					err_d   = res_st.zero ? pfvd_pkg::ERR_ZERO : pfvd_pkg::ERR_POS;
					state_d = pfvd_pkg::ST_ERR;
				end else begin
					state_d = pfvd_pkg::ST_RES_T;
				end
			end
			pfvd_pkg::ST_RES_T: begin
				if (ht_q && (res_st.zero || res_st.bad)) begin
					err_d   = res_st.zero ? pfvd_pkg::ERR_ZERO : pfvd_pkg::ERR_TEX;
					state_d = pfvd_pkg::ST_ERR;
				end else begin
					state_d = pfvd_pkg::ST_RES_N;
				end
			end
			pfvd_pkg::ST_RES_N: begin
				if (hn_q && (res_st.zero || res_st.bad)) begin
					err_d   = res_st.zero ? pfvd_pkg::ERR_ZERO : pfvd_pkg::ERR_NORMAL;
					state_d = pfvd_pkg::ST_ERR;
				end else begin
					state_d = pfvd_pkg::ST_SEARCH;
				end
			end
			pfvd_pkg::ST_SEARCH: begin
				if (scan_done) begin
					if (table_full) begin
						err_d   = pfvd_pkg::ERR_FULL;
						state_d = pfvd_pkg::ST_ERR;
					end else begin
						tbl_we  = 1'b1;
						state_d = pfvd_pkg::ST_EMIT;
					end
				end else begin
					state_d = pfvd_pkg::ST_CMP;
				end
			end
			pfvd_pkg::ST_CMP: begin
				state_d = match ? pfvd_pkg::ST_EMIT : pfvd_pkg::ST_SEARCH;
			end
			pfvd_pkg::ST_EMIT: begin
				if (mask_q == '0) begin
					state_d = pfvd_pkg::ST_IDLE;
				end else if (slot_free) begin
					out_load = 1'b1;
				end
			end
			pfvd_pkg::ST_ERR: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = pfvd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfvd_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfvd_pkg::ST_IDLE;
			err_q   <= pfvd_pkg::ERR_ZERO;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	// corner capture and resolved indices
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_raw_q <= s_axis_tdata[21:0];
			tex_raw_q <= s_axis_tdata[43:22];
			nrm_raw_q <= s_axis_tdata[65:44];
			ht_q      <= s_axis_tdata[66];
			hn_q      <= s_axis_tdata[67];
			pos_cnt_q <= s_axis_tdata[88:68];
			tex_cnt_q <= s_axis_tdata[109:89];
			nrm_cnt_q <= s_axis_tdata[130:110];
			end_q     <= s_axis_tlast;
		end
		if (state_q == pfvd_pkg::ST_RES_P) begin
			p_q <= res_idx;
		end
		if (state_q == pfvd_pkg::ST_RES_T) begin
			t_q <= ht_q ? res_idx : '0;
		end
		if (state_q == pfvd_pkg::ST_RES_N) begin
			n_q <= hn_q ? res_idx : '0;
		end
	end

	// edge endpoint ordering
	always_comb begin
		lo_p = (prev_p_q < p_q) ? prev_p_q : p_q;
		hi_p = (prev_p_q < p_q) ? p_q : prev_p_q;
		lo_f = (first_p_q < p_q) ? first_p_q : p_q;
		hi_f = (first_p_q < p_q) ? p_q : first_p_q;
	end

	// scan pointer, table fill, pending results, face state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			count_q    <= '0;
			ri_q       <= '0;
			new_q      <= 1'b0;
			mask_q     <= '0;
			first_p_q  <= '0;
			prev_p_q   <= '0;
			first_ri_q <= '0;
			prev_ri_q  <= '0;
			cnum_q     <= '0;
			fail_q     <= 1'b0;
		end else begin
			if (state_q == pfvd_pkg::ST_RES_N) begin
				idx_q <= '0;
			end
			if ((state_q == pfvd_pkg::ST_CMP) && !match) begin
				idx_q <= idx_q + 1'b1;
			end
			// hit: reuse entry
			if ((state_q == pfvd_pkg::ST_CMP) && match) begin
				ri_q   <= idx_q[AW-1:0];
				new_q  <= 1'b0;
				mask_q <= mask_init;
			end
			// miss: append
			if (tbl_we) begin
				ri_q    <= count_q[AW-1:0];
				new_q   <= 1'b1;
				count_q <= count_q + 1'b1;
				mask_q  <= mask_init | MASK_W_VERT;
			end
			if (out_load && (state_q == pfvd_pkg::ST_EMIT)) begin
				mask_q <= mask_rest;
			end
			// dropped corners of a failed face
			if (acc && fail_q && s_axis_tlast) begin
				fail_q <= 1'b0;
			end
			if (out_load && (state_q == pfvd_pkg::ST_ERR)) begin
				cnum_q <= '0;
				fail_q <= !end_q;
			end
			// corner done: advance the fan
			if (commit) begin
				if (cnum_q == '0) begin
					first_p_q  <= p_q;
					first_ri_q <= ri_q;
				end
				prev_p_q  <= p_q;
				prev_ri_q <= ri_q;
				if (end_q) begin
					cnum_q <= '0;
				end else if (cnum_q != 8'd255) begin
					cnum_q <= cnum_q + 8'd1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// next result: lowest pending mask bit first, error alone
	always_comb begin
		out_data_d = '0;
		out_kind_d = pfvd_pkg::KIND_RTRI;
		out_last_d = (mask_rest == '0);
		if (state_q == pfvd_pkg::ST_ERR) begin
			out_kind_d        = pfvd_pkg::KIND_ERROR;
			out_data_d[76:74] = err_q;
			out_last_d        = 1'b1;
		end else if (mask_q[pfvd_pkg::M_VERT]) begin
			out_kind_d        = pfvd_pkg::KIND_VERTEX;
			out_data_d[11:0]  = pfvd_pkg::RI_OUT_W'(ri_q);
			out_data_d[31:12] = pfvd_pkg::OUT_IDX_W'(p_q);
			out_data_d[51:32] = pfvd_pkg::OUT_IDX_W'(t_q);
			out_data_d[71:52] = pfvd_pkg::OUT_IDX_W'(n_q);
			out_data_d[72]    = ht_q;
			out_data_d[73]    = hn_q;
		end else if (mask_q[pfvd_pkg::M_EDGEP]) begin
			out_kind_d        = pfvd_pkg::KIND_EDGE;
			out_data_d[31:12] = pfvd_pkg::OUT_IDX_W'(lo_p);
			out_data_d[51:32] = pfvd_pkg::OUT_IDX_W'(hi_p);
		end else if (mask_q[pfvd_pkg::M_EDGEF]) begin
			out_kind_d        = pfvd_pkg::KIND_EDGE;
			out_data_d[31:12] = pfvd_pkg::OUT_IDX_W'(lo_f);
			out_data_d[51:32] = pfvd_pkg::OUT_IDX_W'(hi_f);
		end else if (mask_q[pfvd_pkg::M_PTRI]) begin
			out_kind_d        = pfvd_pkg::KIND_PTRI;
			out_data_d[31:12] = pfvd_pkg::OUT_IDX_W'(first_p_q);
			out_data_d[51:32] = pfvd_pkg::OUT_IDX_W'(prev_p_q);
			out_data_d[71:52] = pfvd_pkg::OUT_IDX_W'(p_q);
		end else begin
			out_kind_d        = pfvd_pkg::KIND_RTRI;
			out_data_d[31:12] = pfvd_pkg::OUT_IDX_W'(first_ri_q);
			out_data_d[51:32] = pfvd_pkg::OUT_IDX_W'(prev_ri_q);
			out_data_d[71:52] = pfvd_pkg::OUT_IDX_W'(ri_q);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= out_data_d;
			m_axis_tuser <= out_kind_d;
			m_axis_tlast <= out_last_d;
		end
	end

`ifndef SYNTHESIS
	// table fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("vertex count beyond table depth");

	// an error result is always the final result of its corner
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == pfvd_pkg::KIND_ERROR)) |-> m_axis_tlast)
		else $error("error result not marked last");

	// a failed face keeps its corner count at zero
	a_fail_cnum: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q |-> (cnum_q == '0))
		else $error("corner count running in failed face");

	// an insert always announces a new vertex first
	a_insert_vert: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> (new_q && mask_q[pfvd_pkg::M_VERT]))
		else $error("insert without new vertex result");
`endif

endmodule

// ===== hw/rtl/pfvd_resolve.sv =====
// Shared index resolver: one-based signed OBJ index to zero-based with range check.
// Depends on pfvd_pkg.
module pfvd_resolve #(
	parameter int INDEX_BITS = 20
) (
	input  logic [pfvd_pkg::RAW_W-1:0]   raw,
	input  logic [pfvd_pkg::COUNT_W-1:0] count,
	output pfvd_pkg::res_status_t        status,
	output logic [INDEX_BITS-1:0]        idx
);

	logic [pfvd_pkg::RAW_W:0] v;
	logic [pfvd_pkg::RAW_W:0] r;
	logic                     positive;

	// positive: v - 1, negative: count + v (two's complement in 23 bits)
	always_comb begin
		v        = {raw[pfvd_pkg::RAW_W-1], raw};
		positive = !raw[pfvd_pkg::RAW_W-1] && (raw != '0);
		if (positive) begin
			r = v - 23'd1;
		end else begin
			r = {2'b00, count} + v;
		end
		status.zero = (raw == '0);
		status.bad  = r[pfvd_pkg::RAW_W] ||
			(r[pfvd_pkg::RAW_W-1:0] >= {1'b0, count}) ||
			(|r[pfvd_pkg::RAW_W-1:INDEX_BITS]);
		idx = r[INDEX_BITS-1:0];
	end

endmodule

// ===== hw/rtl/pfvd_table.sv =====
// Dedup key store: one write port, one read port with registered read data.
// No dependencies.
module pfvd_table #(
	parameter int DEPTH  = 4096,
	parameter int WIDTH  = 62,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
